FILE: hdl/gaussian_deviate_generator_top_defines.svh
// ---------------------------------------------------------------------------
// gaussian deviate generator assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_DEVIATE_GENERATOR_TOP_DEFINES_SVH
`define GAUSSIAN_DEVIATE_GENERATOR_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GDG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define GDG_ASSERT_DELAY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

FILE: hdl/gdg_pkg.sv
// ---------------------------------------------------------------------------
// gdg_pkg
// widths, coefficients and shared types of the gaussian deviate generator
// ---------------------------------------------------------------------------
`default_nettype none

package gdg_pkg;

    // uniform input width and log2 format
    localparam int UNIFORM_BITS = 24;
    localparam int LOG_FRAC     = 16;
    localparam int EXP_W        = 5;
    localparam int MANT_W       = 31;

    // -2 ln p path widths
    localparam int D_W  = $clog2((UNIFORM_BITS << LOG_FRAC) + 1);
    localparam int W_W  = D_W + 1;
    localparam int SQ_W = W_W + LOG_FRAC;
    localparam int T_W  = (SQ_W + 1) / 2;

    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

    // rational approximation coefficients, q.24
    localparam logic [25:0] COEF_C0 = 26'd42203372;
    localparam logic [23:0] COEF_C1 = 24'd13469638;
    localparam logic [17:0] COEF_C2 = 18'd173275;
    localparam logic [24:0] COEF_D1 = 25'd24038194;
    localparam logic [21:0] COEF_D2 = 22'd3175407;
    localparam logic [14:0] COEF_D3 = 15'd21945;
    localparam logic [24:0] ONE_Q24 = 25'd16777216;

    // horner and divider widths, bounded by t below 2^19
    localparam int A1_W  = 25;
    localparam int B1_W  = 23;
    localparam int NUM_W = 28;
    localparam int B2_W  = 26;
    localparam int DEN_W = 29;
    localparam int Q_W   = 20;
    localparam int N_W   = NUM_W + LOG_FRAC + 1;
    localparam int Z_W   = Q_W + 1;

    // result widths
    localparam int CFG_W = 16;
    localparam int DEV_W = 16;
    localparam int SMP_W = 24;

    // stage counts per unit
    localparam int LOG_LAT   = LOG_FRAC + 5;
    localparam int RATIO_LAT = Q_W + 5;
    localparam int SCALE_LAT = 3;
    localparam int PIPE_LAT  = LOG_LAT + T_W + RATIO_LAT + SCALE_LAT;

    // item tag travelling beside the data
    typedef struct packed {
        logic valid;
        logic lower;
    } gdg_tag_t;

    // register index on the config port
    typedef enum logic {
        REG_MEAN    = 1'b0,
        REG_STD_DEV = 1'b1
    } gdg_reg_t;

endpackage

`default_nettype wire

FILE: hdl/gdg_log2.sv
// ---------------------------------------------------------------------------
// gdg_log2
// tail probability, log2 by repeated squaring and w = -2 ln p in q.16
// ---------------------------------------------------------------------------
`default_nettype none

module gdg_log2 (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic [gdg_pkg::UNIFORM_BITS-1:0]  in_code,
    output gdg_pkg::gdg_tag_t                      out_tag,
    output logic      [gdg_pkg::W_W-1:0]           out_w
);
    import gdg_pkg::*;

    localparam int SQS = LOG_FRAC;

    gdg_tag_t                  tag_reg [0:LOG_LAT-1];
    gdg_tag_t                  tag_next;
    logic [UNIFORM_BITS-1:0]   code_fix;
    logic [UNIFORM_BITS-1:0]   p_next;
    logic [UNIFORM_BITS-1:0]   p0_reg;
    logic [UNIFORM_BITS-1:0]   p1_reg;
    logic [EXP_W-1:0]          e_next;
    logic [EXP_W-1:0]          e1_reg;
    logic [UNIFORM_BITS+MANT_W-2:0] shl;
    logic [MANT_W-1:0]         m_reg    [0:SQS];
    logic [MANT_W-1:0]         m_next   [1:SQS];
    logic [LOG_FRAC-1:0]       frac_reg [0:SQS];
    logic [LOG_FRAC-1:0]       frac_next[1:SQS];
    logic [EXP_W-1:0]          e_reg    [0:SQS];
    logic [D_W-1:0]            d_next;
    logic [D_W-1:0]            d_reg;
    logic [D_W+30:0]           w_prod;
    logic [D_W+31:0]           w_sum;
    logic [W_W-1:0]            w_reg;

    // code 0 taken as 1, upper half mirrored
    always_comb
    begin
        code_fix       = (in_code == '0) ? UNIFORM_BITS'(1) : in_code;
        tag_next.valid = in_valid;
        tag_next.lower = !code_fix[UNIFORM_BITS-1];
        p_next         = tag_next.lower ? code_fix : (~code_fix + UNIFORM_BITS'(1));
    end

    // msb position
    always_comb
    begin
        e_next = '0;
        for (int i = 0; i < UNIFORM_BITS; i++)
        begin
            if (p0_reg[i])
            begin
                e_next = EXP_W'(i);
            end
        end
    end

    assign shl = {p1_reg, {(MANT_W-1){1'b0}}} >> e1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOG_LAT; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_next;
            for (int i = 1; i < LOG_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg      <= p_next;
        p1_reg      <= p0_reg;
        e1_reg      <= e_next;
        m_reg[0]    <= shl[MANT_W-1:0];
        frac_reg[0] <= '0;
        e_reg[0]    <= e1_reg;
    end

    // one squaring per stage gives one fraction bit
    for (genvar k = 0; k < SQS; k++)
    begin : g_sq
        logic [2*MANT_W-1:0] prod;
        logic [MANT_W:0]     sq;

        assign prod = m_reg[k] * m_reg[k];
        assign sq   = prod[2*MANT_W-1 -: MANT_W+1];

        always_comb
        begin
            m_next[k+1]    = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
            frac_next[k+1] = {frac_reg[k][LOG_FRAC-2:0], sq[MANT_W]};
        end

        always_ff @(posedge clk)
        begin
            m_reg[k+1]    <= m_next[k+1];
            frac_reg[k+1] <= frac_next[k+1];
            e_reg[k+1]    <= e_reg[k];
        end
    end

    assign d_next = D_W'(UNIFORM_BITS << LOG_FRAC) - D_W'({e_reg[SQS], frac_reg[SQS]});
    assign w_prod = d_reg * TWO_LN2_Q30;
    assign w_sum  = {1'b0, w_prod} + (D_W+32)'(64'd1 << 29);

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
        w_reg <= w_sum[30 +: W_W];
    end

    assign out_tag = tag_reg[LOG_LAT-1];
    assign out_w   = w_reg;

endmodule

`default_nettype wire

FILE: hdl/gdg_sqrt.sv
// ---------------------------------------------------------------------------
// gdg_sqrt
// pipelined integer square root, one result bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module gdg_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gdg_pkg::gdg_tag_t          in_tag,
    input  wire logic [gdg_pkg::W_W-1:0]    in_w,
    output gdg_pkg::gdg_tag_t               out_tag,
    output logic      [gdg_pkg::T_W-1:0]    out_t
);
    import gdg_pkg::*;

    gdg_tag_t          tag_reg [0:T_W-1];
    logic [SQ_W-1:0]   n_reg   [0:T_W-1];
    logic [SQ_W-1:0]   res_reg [0:T_W-1];
    logic [SQ_W-1:0]   n_next  [0:T_W-1];
    logic [SQ_W-1:0]   res_next[0:T_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < T_W; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= in_tag;
            for (int i = 1; i < T_W; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < T_W; k++)
    begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (T_W - 1 - k));
        logic [SQ_W-1:0] n_in;
        logic [SQ_W-1:0] r_in;
        logic [SQ_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign n_in = {in_w, {LOG_FRAC{1'b0}}};
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign n_in = n_reg[k-1];
            assign r_in = res_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_comb
        begin
            if (n_in >= trial)
            begin
                n_next[k]   = n_in - trial;
                res_next[k] = (r_in >> 1) + BIT;
            end
            else
            begin
                n_next[k]   = n_in;
                res_next[k] = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[k]   <= n_next[k];
            res_reg[k] <= res_next[k];
        end
    end

    assign out_tag = tag_reg[T_W-1];
    assign out_t   = res_reg[T_W-1][T_W-1:0];

endmodule

`default_nettype wire

FILE: hdl/gdg_ratio.sv
// ---------------------------------------------------------------------------
// gdg_ratio
// horner evaluation of N(t) and D(t), pipelined divide, z = t - N/D
// ---------------------------------------------------------------------------
`default_nettype none

module gdg_ratio (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gdg_pkg::gdg_tag_t          in_tag,
    input  wire logic [gdg_pkg::T_W-1:0]    in_t,
    output gdg_pkg::gdg_tag_t               out_tag,
    output logic      [gdg_pkg::Z_W-1:0]    out_z
);
    import gdg_pkg::*;

    localparam int PS1_W = $bits(COEF_C2) + T_W;
    localparam int PR1_W = $bits(COEF_D3) + T_W;
    localparam int PS2_W = A1_W + T_W;
    localparam int PR2_W = B1_W + T_W;
    localparam int PR3_W = B2_W + T_W;
    localparam int CMP_W = DEN_W + Q_W;
    localparam logic [16:0] HALF = 17'd32768;

    gdg_tag_t          tag_reg [0:RATIO_LAT-1];

    logic [PS1_W-1:0]  ps1;
    logic [PS1_W:0]    rs1;
    logic [PR1_W-1:0]  pr1;
    logic [PR1_W:0]    rr1;
    logic [A1_W-1:0]   a1_reg;
    logic [B1_W-1:0]   b1_reg;
    logic [T_W-1:0]    t1_reg;

    logic [PS2_W-1:0]  ps2;
    logic [PS2_W:0]    rs2;
    logic [PR2_W-1:0]  pr2;
    logic [PR2_W:0]    rr2;
    logic [NUM_W-1:0]  num2_reg;
    logic [B2_W-1:0]   b2_reg;
    logic [T_W-1:0]    t2_reg;

    logic [PR3_W-1:0]  pr3;
    logic [PR3_W:0]    rr3;
    logic [NUM_W-1:0]  num3_reg;
    logic [DEN_W-1:0]  den3_reg;
    logic [T_W-1:0]    t3_reg;

    logic [N_W-1:0]    rem_reg [0:Q_W];
    logic [Q_W-1:0]    q_reg   [0:Q_W];
    logic [DEN_W-1:0]  den_reg [0:Q_W];
    logic [T_W-1:0]    t_reg   [0:Q_W];
    logic [N_W-1:0]    rem_next[1:Q_W];
    logic [Q_W-1:0]    q_next  [1:Q_W];
    logic [Z_W-1:0]    z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RATIO_LAT; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= in_tag;
            for (int i = 1; i < RATIO_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // each product rounded to q.16 of t
    assign ps1 = COEF_C2 * in_t;
    assign rs1 = {1'b0, ps1} + (PS1_W+1)'(HALF);
    assign pr1 = COEF_D3 * in_t;
    assign rr1 = {1'b0, pr1} + (PR1_W+1)'(HALF);

    assign ps2 = a1_reg * t1_reg;
    assign rs2 = {1'b0, ps2} + (PS2_W+1)'(HALF);
    assign pr2 = b1_reg * t1_reg;
    assign rr2 = {1'b0, pr2} + (PR2_W+1)'(HALF);

    assign pr3 = b2_reg * t2_reg;
    assign rr3 = {1'b0, pr3} + (PR3_W+1)'(HALF);

    always_ff @(posedge clk)
    begin
        a1_reg   <= A1_W'(rs1[PS1_W:16]) + A1_W'(COEF_C1);
        b1_reg   <= B1_W'(rr1[PR1_W:16]) + B1_W'(COEF_D2);
        t1_reg   <= in_t;
        num2_reg <= NUM_W'(rs2[PS2_W:16]) + NUM_W'(COEF_C0);
        b2_reg   <= B2_W'(rr2[PR2_W:16]) + B2_W'(COEF_D1);
        t2_reg   <= t1_reg;
        num3_reg <= num2_reg;
        den3_reg <= DEN_W'(rr3[PR3_W:16]) + DEN_W'(ONE_Q24);
        t3_reg   <= t2_reg;
        // dividend with half the divisor for rounding
        rem_reg[0] <= {1'b0, num3_reg, {LOG_FRAC{1'b0}}} + N_W'(den3_reg >> 1);
        q_reg[0]   <= '0;
        den_reg[0] <= den3_reg;
        t_reg[0]   <= t3_reg;
    end

    // restoring divide, msb first
    for (genvar k = 1; k <= Q_W; k++)
    begin : g_div
        localparam int SH = Q_W - k;
        logic [CMP_W-1:0] dsh;
        logic [CMP_W-1:0] rext;

        assign dsh  = CMP_W'(den_reg[k-1]) << SH;
        assign rext = CMP_W'(rem_reg[k-1]);

        always_comb
        begin
            if (rext >= dsh)
            begin
                rem_next[k] = N_W'(rext - dsh);
                q_next[k]   = q_reg[k-1] | (Q_W'(1) << SH);
            end
            else
            begin
                rem_next[k] = rem_reg[k-1];
                q_next[k]   = q_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next[k];
            q_reg[k]   <= q_next[k];
            den_reg[k] <= den_reg[k-1];
            t_reg[k]   <= t_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg <= Z_W'(t_reg[Q_W]) - Z_W'(q_reg[Q_W]);
    end

    assign out_tag = tag_reg[RATIO_LAT-1];
    assign out_z   = z_reg;

endmodule

`default_nettype wire

FILE: hdl/gdg_scale.sv
// ---------------------------------------------------------------------------
// gdg_scale
// rounds z to q4.12, applies sign, scales by std dev and adds the mean
// ---------------------------------------------------------------------------
`default_nettype none

module gdg_scale (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire gdg_pkg::gdg_tag_t                 in_tag,
    input  wire logic        [gdg_pkg::Z_W-1:0]    in_z,
    input  wire logic signed [gdg_pkg::CFG_W-1:0]  mean,
    input  wire logic        [gdg_pkg::CFG_W-1:0]  std_dev,
    output logic                                   done,
    output logic signed      [gdg_pkg::DEV_W-1:0]  deviate,
    output logic signed      [gdg_pkg::SMP_W-1:0]  sample,
    output logic                                   saturated
);
    import gdg_pkg::*;

    localparam int PRD_W = CFG_W + DEV_W + 1;
    localparam int RS_W  = PRD_W - 8 + 1;
    localparam int SUM_W = RS_W + 1;
    localparam logic signed [Z_W-3:0] DEV_MAX = (Z_W-2)'(2 ** (DEV_W - 1) - 1);
    localparam logic signed [Z_W-3:0] DEV_MIN = -(Z_W-2)'(2 ** (DEV_W - 1));
    localparam logic signed [SUM_W-1:0] SMP_MAX = SUM_W'(2 ** (SMP_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SMP_MIN = -SUM_W'(2 ** (SMP_W - 1));

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       done_reg;
    logic [Z_W-1:0]             zmag;
    logic [Z_W:0]               zrnd;
    logic                       neg;
    logic signed [Z_W-3:0]      dv;
    logic signed [DEV_W-1:0]    dev_next;
    logic signed [DEV_W-1:0]    dev1_reg;
    logic signed [DEV_W-1:0]    dev2_reg;
    logic signed [DEV_W-1:0]    dev3_reg;
    logic signed [PRD_W-1:0]    prod2_reg;
    logic [PRD_W-1:0]           pmag;
    logic [PRD_W-1:0]           prnd;
    logic signed [RS_W-1:0]     rs;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SMP_W-1:0]    smp_next;
    logic signed [SMP_W-1:0]    smp_reg;
    logic                       sat_next;
    logic                       sat_reg;

    // round half away from zero to q.12, then fold in the branch sign
    always_comb
    begin
        zmag = in_z[Z_W-1] ? (~in_z + Z_W'(1)) : in_z;
        zrnd = {1'b0, zmag} + (Z_W+1)'(8);
        neg  = in_z[Z_W-1] ^ in_tag.lower;
        dv   = neg ? -$signed({1'b0, zrnd[Z_W:4]}) : $signed({1'b0, zrnd[Z_W:4]});
        if (dv > DEV_MAX)
        begin
            dev_next = DEV_W'(DEV_MAX);
        end
        else if (dv < DEV_MIN)
        begin
            dev_next = DEV_W'(DEV_MIN);
        end
        else
        begin
            dev_next = DEV_W'(dv);
        end
    end

    // scaled deviate back to q.12, plus mean, then clip
    // magnitude stays below 2^31, so the rounded value fits below the top bit
    always_comb
    begin
        pmag = prod2_reg[PRD_W-1] ? PRD_W'(-prod2_reg) : PRD_W'(prod2_reg);
        prnd = pmag + PRD_W'(128);
        rs   = prod2_reg[PRD_W-1] ? -$signed({1'b0, prnd[PRD_W-1:8]})
                                  : $signed({1'b0, prnd[PRD_W-1:8]});
        sum  = SUM_W'(rs) + SUM_W'($signed({mean, 4'b0000}));
        priority if (sum > SMP_MAX)
        begin
            smp_next = SMP_W'(SMP_MAX);
            sat_next = 1'b1;
        end
        else if (sum < SMP_MIN)
        begin
            smp_next = SMP_W'(SMP_MIN);
            sat_next = 1'b1;
        end
        else
        begin
            smp_next = SMP_W'(sum);
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_tag.valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dev1_reg  <= dev_next;
        prod2_reg <= $signed({1'b0, std_dev}) * dev1_reg;
        dev2_reg  <= dev1_reg;
        dev3_reg  <= dev2_reg;
        smp_reg   <= smp_next;
        sat_reg   <= sat_next;
    end

    assign done      = done_reg;
    assign deviate   = dev3_reg;
    assign sample    = smp_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

FILE: hdl/gaussian_deviate_generator_top.sv
// ---------------------------------------------------------------------------
// gaussian_deviate_generator_top
// uniform code to normal deviate and scaled sample, full-rate pipeline
// ---------------------------------------------------------------------------
// pipeline: 21 log2, 19 root, 25 rational and divide and 3 scale stages
//   lie between start and the done strobe
// throughput: one item per cycle; busy stays low, every stage moves each cycle
// the receiver cannot stall, so done is a single-cycle strobe per item
// reset: rst_n clears all valid bits and sets mean to 0, std_dev to 1.0
// ---------------------------------------------------------------------------
`default_nettype none
`include "gaussian_deviate_generator_top_defines.svh"

module gaussian_deviate_generator_top (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // item input
    input  wire logic                                     start,
    output logic                                          busy,
    input  wire logic        [gdg_pkg::UNIFORM_BITS-1:0]  uniform_code,
    // result output
    output logic                                          done,
    output logic signed      [gdg_pkg::DEV_W-1:0]         deviate,
    output logic signed      [gdg_pkg::SMP_W-1:0]         sample,
    output logic                                          saturated,
    // register port
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic        [2:0]                        paddr,
    input  wire logic        [31:0]                       pwdata,
    output logic             [31:0]                       prdata,
    output logic                                          pready
);
    import gdg_pkg::*;

    logic signed [CFG_W-1:0]  mean_reg;
    logic signed [CFG_W-1:0]  mean_next;
    logic [CFG_W-1:0]         std_dev_reg;
    logic [CFG_W-1:0]         std_dev_next;
    gdg_reg_t                 reg_sel;
    logic                     cfg_wr;
    logic                     accept;

    gdg_tag_t                 log_tag;
    logic [W_W-1:0]           log_w;
    gdg_tag_t                 root_tag;
    logic [T_W-1:0]           root_t;
    gdg_tag_t                 ratio_tag;
    logic [Z_W-1:0]           ratio_z;

    // no backpressure anywhere, so an item is taken on every start
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;

    // register decode on word address
    assign reg_sel = gdg_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        mean_next    = mean_reg;
        std_dev_next = std_dev_reg;
        if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_MEAN:    mean_next    = pwdata[CFG_W-1:0];
                REG_STD_DEV: std_dev_next = pwdata[CFG_W-1:0];
                default:     mean_next    = mean_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg    <= '0;
            std_dev_reg <= CFG_W'(256);
        end
        else
        begin
            mean_reg    <= mean_next;
            std_dev_reg <= std_dev_next;
        end
    end

    // read back, mean sign-extended
    always_comb
    begin
        unique case (reg_sel)
            REG_MEAN:    prdata = {{(32-CFG_W){mean_reg[CFG_W-1]}}, mean_reg};
            REG_STD_DEV: prdata = {{(32-CFG_W){1'b0}}, std_dev_reg};
            default:     prdata = '0;
        endcase
    end

    // tail probability and -2 ln p
    gdg_log2 u_log2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_code  (uniform_code),
        .out_tag  (log_tag),
        .out_w    (log_w)
    );

    // t = sqrt(w)
    gdg_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (log_tag),
        .in_w    (log_w),
        .out_tag (root_tag),
        .out_t   (root_t)
    );

    // z = t - N(t)/D(t)
    gdg_ratio u_ratio (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (root_tag),
        .in_t    (root_t),
        .out_tag (ratio_tag),
        .out_z   (ratio_z)
    );

    // rounding, sign and mean/std scaling
    gdg_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tag    (ratio_tag),
        .in_z      (ratio_z),
        .mean      (mean_reg),
        .std_dev   (std_dev_reg),
        .done      (done),
        .deviate   (deviate),
        .sample    (sample),
        .saturated (saturated)
    );

    // every accepted item comes out after the fixed pipeline depth
    `GDG_ASSERT_DELAY(a_latency, accept, PIPE_LAT, done, "item lost in pipeline")
    // a clipped sample sits at a rail
    `GDG_ASSERT_IMPL(a_sat_rail, done && saturated, (sample == 24'sh7FFFFF) || (sample == -24'sh800000), "saturated sample off rail")
    // unit scale and zero mean pass the deviate straight through
    `GDG_ASSERT_IMPL(a_unit_scale, done && ($past(mean_reg) == 16'sd0) && ($past(std_dev_reg, 2) == 16'd256), !saturated && (sample == SMP_W'(deviate)), "unit scale mismatch")

endmodule

`default_nettype wire
